// ----- design/rau_pkg.sv -----
// Shared types and codes for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  localparam logic [2:0] K_ADD   = 3'd0;
  localparam logic [2:0] K_SUB   = 3'd1;
  localparam logic [2:0] K_MUL   = 3'd2;
  localparam logic [2:0] K_DIV   = 3'd3;
  localparam logic [2:0] K_EQ    = 3'd4;
  localparam logic [2:0] K_LT    = 3'd5;
  localparam logic [2:0] K_LE    = 3'd6;
  localparam logic [2:0] K_MAKE  = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               truth;
    logic [1:0]         status;
  } rau_out_t;

endpackage
`default_nettype wire

// ----- design/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit: sequencer, shared multiplier, output register.
// Each operand and, for the arithmetic kinds, the result pass through the reducer (binary
// gcd, then two bit-serial divisions by the gcd); an operand with a zero denominator ends
// the item early with status ST_ZERO.
// Throughput: one item at a time; in_ready is high only while the sequencer is idle.
// Reset: synchronous, active high; clears the sequencer and the output valid.
`default_nettype none
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rau_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output rau_out_t      out_data
);

  localparam int EW = (OPERAND_WIDTH > 32) ? 32 : OPERAND_WIDTH;
  localparam int SH = 32 - EW;
  localparam logic [63:0] LIM = 64'd1 << (EW - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LDA  = 4'd1;
  localparam logic [3:0] S_REDA = 4'd2;
  localparam logic [3:0] S_LDB  = 4'd3;
  localparam logic [3:0] S_REDB = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_COMB = 4'd6;
  localparam logic [3:0] S_RGO  = 4'd7;
  localparam logic [3:0] S_REDR = 4'd8;
  localparam logic [3:0] S_CHK  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  function automatic logic signed [31:0] sext(input logic [31:0] f);
    logic signed [31:0] t;
    t = $signed(f << SH);
    return t >>> SH;
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] s);
    return s[31] ? (~s + 32'd1) : s;
  endfunction

  logic [3:0]  state;
  rau_in_t     req;
  rau_out_t    res;
  logic [31:0] an, ad, bn, bd;
  logic        aneg, bneg, rneg;
  logic [63:0] rn, rd, p0, p1, p2;
  logic [1:0]  step;

  logic signed [31:0] s_an, s_ad, s_bn, s_bd;
  logic        red_start, red_done;
  logic [63:0] red_nin, red_din, red_n, red_d;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic        red_neg;

  assign s_an = sext(req.a_num);
  assign s_ad = sext(req.a_den);
  assign s_bn = sext(req.b_num);
  assign s_bd = sext(req.b_den);

  assign in_ready = (state == S_IDLE);

  assign red_start = (state == S_LDA && s_ad != 32'sd0) ||
                     (state == S_LDB && s_bd != 32'sd0) || (state == S_RGO);

  always_comb begin
    red_nin = rn;
    red_din = rd;
    if (state == S_LDA) begin
      red_nin = {32'd0, mag(s_an)};
      red_din = {32'd0, mag(s_ad)};
    end else if (state == S_LDB) begin
      red_nin = {32'd0, mag(s_bn)};
      red_din = {32'd0, mag(s_bd)};
    end
  end

  rau_reduce u_reduce (
    .clk   (clk),
    .rst   (rst),
    .start (red_start),
    .n_in  (red_nin),
    .d_in  (red_din),
    .done  (red_done),
    .n_out (red_n),
    .d_out (red_d)
  );

  // a zero numerator carries no sign
  assign red_neg = (red_n == 64'd0) ? 1'b0 : rneg;

  always_comb begin
    case (step)
      2'd0: begin
        ma = an;
        mb = (req.kind == K_MUL) ? bn : bd;
      end
      2'd1: begin
        ma = bn;
        mb = ad;
      end
      default: begin
        ma = ad;
        mb = bd;
      end
    endcase
    prod = 64'(ma) * 64'(mb);
  end

  // comparison and add/sub combine
  logic sx, sy, lt, eqv, sb;
  always_comb begin
    sx  = aneg && (p0 != 64'd0);
    sy  = bneg && (p1 != 64'd0);
    eqv = (sx == sy) && (p0 == p1);
    if (sx != sy)
      lt = sx;
    else if (p0 == p1)
      lt = 1'b0;
    else if (!sx)
      lt = p0 < p1;
    else
      lt = p0 > p1;
    sb = ((req.kind == K_SUB) ? !bneg : bneg) && (bn != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE)
        out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            res   <= '0;
            state <= S_LDA;
          end
        end
        S_LDA: begin
          rneg <= s_an[31] ^ s_ad[31];
          if (s_ad == 32'sd0) begin
            res.status <= ST_ZERO;
            state      <= S_DONE;
          end else begin
            state <= S_REDA;
          end
        end
        S_REDA: begin
          if (red_done) begin
            an   <= red_n[31:0];
            ad   <= red_d[31:0];
            aneg <= red_neg;
            if (req.kind == K_MAKE) begin
              rn    <= red_n;
              rd    <= red_d;
              rneg  <= red_neg;
              state <= S_CHK;
            end else begin
              state <= S_LDB;
            end
          end
        end
        S_LDB: begin
          rneg <= s_bn[31] ^ s_bd[31];
          if (s_bd == 32'sd0) begin
            res.status <= ST_ZERO;
            state      <= S_DONE;
          end else begin
            state <= S_REDB;
          end
        end
        S_REDB: begin
          if (red_done) begin
            bn   <= red_n[31:0];
            bd   <= red_d[31:0];
            bneg <= red_neg;
            step <= 2'd0;
            if (req.kind == K_EQ) begin
              res.truth <= (aneg == red_neg) && ({32'd0, an} == red_n) &&
                           ({32'd0, ad} == red_d);
              state     <= S_DONE;
            end else if (req.kind == K_DIV && red_n == 64'd0) begin
              res.status <= ST_ZERO;
              state      <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          step <= step + 2'd1;
          case (step)
            2'd0:    p0 <= prod;
            2'd1:    p1 <= prod;
            default: begin
              p2    <= prod;
              state <= S_COMB;
            end
          endcase
        end
        S_COMB: begin
          case (req.kind)
            K_LT, K_LE: begin
              res.truth <= (req.kind == K_LT) ? lt : (lt | eqv);
              state     <= S_DONE;
            end
            K_ADD, K_SUB: begin
              rd    <= p2;
              state <= S_RGO;
              if (aneg == sb) begin
                rn   <= p0 + p1;
                rneg <= aneg;
              end else if (p0 >= p1) begin
                rn   <= p0 - p1;
                rneg <= aneg;
              end else begin
                rn   <= p1 - p0;
                rneg <= sb;
              end
            end
            K_MUL: begin
              rn    <= p0;
              rd    <= p2;
              rneg  <= aneg ^ bneg;
              state <= S_RGO;
            end
            default: begin
              rn    <= p0;
              rd    <= p1;
              rneg  <= aneg ^ bneg;
              state <= S_RGO;
            end
          endcase
        end
        S_RGO: begin
          state <= S_REDR;
        end
        S_REDR: begin
          if (red_done) begin
            rn    <= red_n;
            rd    <= red_d;
            rneg  <= red_neg;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (rd > LIM - 64'd1 || (rneg ? rn > LIM : rn > LIM - 64'd1)) begin
            res.status <= ST_OVF;
          end else begin
            res.res_num <= rneg ? $signed(32'd0 - rn[31:0]) : $signed(rn[31:0]);
            res.res_den <= rd[30:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/rau_reduce.sv -----
// Fraction reducer: binary gcd, then two bit-serial divisions by the gcd.
`default_nettype none
module rau_reduce
  import rau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] n_in,
  input  wire logic [63:0] d_in,
  output logic             done,
  output logic [63:0]      n_out,
  output logic [63:0]      d_out
);

  localparam logic [2:0] R_IDLE = 3'd0;
  localparam logic [2:0] R_GCD  = 3'd1;
  localparam logic [2:0] R_DIVN = 3'd2;
  localparam logic [2:0] R_DIVD = 3'd3;
  localparam logic [2:0] R_DONE = 3'd4;

  logic [2:0]  state;
  logic [63:0] n, d, u, v, g, quo, rem;
  logic [5:0]  k, cnt;

  logic [64:0] tmp, diff;
  logic        ge;
  logic [63:0] quo_next, rem_next;

  always_comb begin
    tmp      = {rem, quo[63]};
    diff     = tmp - {1'b0, g};
    ge       = tmp >= {1'b0, g};
    rem_next = ge ? diff[63:0] : tmp[63:0];
    quo_next = {quo[62:0], ge};
  end

  assign done  = (state == R_DONE);
  assign n_out = n;
  assign d_out = d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      case (state)
        R_IDLE: begin
          if (start) begin
            n <= n_in;
            if (n_in == 64'd0) begin
              d     <= 64'd1;
              state <= R_DONE;
            end else begin
              d     <= d_in;
              u     <= n_in;
              v     <= d_in;
              k     <= 6'd0;
              state <= R_GCD;
            end
          end
        end
        R_GCD: begin
          if (v == 64'd0) begin
            g     <= u << k;
            quo   <= n;
            rem   <= 64'd0;
            cnt   <= 6'd0;
            state <= R_DIVN;
          end else if (!u[0] && !v[0]) begin
            // strip common factors of two
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 6'd1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u > v) begin
            u <= v;
            v <= u - v;
          end else begin
            v <= v - u;
          end
        end
        R_DIVN: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            n   <= quo_next;
            quo <= d;
            rem <= 64'd0;
            state <= R_DIVD;
          end else begin
            quo <= quo_next;
            rem <= rem_next;
          end
        end
        R_DIVD: begin
          cnt <= cnt + 6'd1;
          quo <= quo_next;
          rem <= rem_next;
          if (cnt == 6'd63) begin
            d     <= quo_next;
            state <= R_DONE;
          end
        end
        R_DONE: begin
          state <= R_IDLE;
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/rau_checker.sv -----
// Port-level checks for the rational arithmetic unit, bound to the top level.
`default_nettype none
module rau_checker
  import rau_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire rau_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("took an item while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      out_data.res_num == 32'sd0 && out_data.res_den == 31'd0 && !out_data.truth)
    else $error("error result carries data");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_ZERO ||
                  out_data.status == ST_OVF)
    else $error("bad status code");

  a_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_OK && out_data.res_den == 31'd0 |->
      out_data.res_num == 32'sd0)
    else $error("numerator with zero denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the rational arithmetic unit.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  rau_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  rau_out_t out_data;

  rational_arithmetic_unit #(.OPERAND_WIDTH(32)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  rau_in_t  pending_items[$];
  rau_out_t expected_results[$];
  int       n_errors = 0;
  int       cycle_count;
  int       hold_off;
  bit       in_accepted;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Euclid gcd, zero maps to one
  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return (x == 0) ? 64'd1 : x;
  endfunction

  function automatic void split(logic [31:0] raw, output bit neg, output logic [63:0] mag);
    neg = raw[31];
    mag = raw[31] ? {32'd0, (~raw) + 32'd1} : {32'd0, raw};
    if (raw == 32'h8000_0000) mag = 64'h8000_0000;
  endfunction

  function automatic void reduce_frac(inout bit neg, inout logic [63:0] n,
                                      inout logic [63:0] d);
    logic [63:0] g;
    g = gcd64(n, d);
    n = n / g;
    d = d / g;
    if (n == 0) begin
      neg = 1'b0;
      d = 64'd1;
    end
  endfunction

  function automatic bit load_frac(logic [31:0] num, logic [31:0] den, output bit neg,
                                   output logic [63:0] n, output logic [63:0] d);
    bit sn, sd;
    split(num, sn, n);
    split(den, sd, d);
    neg = (sn != sd);
    if (d == 0) return 1'b0;
    reduce_frac(neg, n, d);
    return 1'b1;
  endfunction

  function automatic int cmp_signed_mag(bit sx, logic [63:0] x, bit sy, logic [63:0] y);
    if (x == 0) sx = 1'b0;
    if (y == 0) sy = 1'b0;
    if (sx != sy) return sx ? -1 : 1;
    if (x == y) return 0;
    if (!sx) return (x < y) ? -1 : 1;
    return (x < y) ? 1 : -1;
  endfunction

  function automatic rau_out_t compute_rational(rau_in_t it);
    rau_out_t    o;
    bit          an, bn, rn, sb;
    logic [63:0] a_n, a_d, b_n, b_d, r_n, r_d, x, y;
    logic [63:0] lim;
    int          c;
    o = '0;
    lim = 64'h8000_0000;
    if (!load_frac(it.a_num, it.a_den, an, a_n, a_d)) begin
      o.status = ST_ZERO;
      return o;
    end
    if (it.kind == K_MAKE) begin
      rn = an; r_n = a_n; r_d = a_d;
    end else begin
      if (!load_frac(it.b_num, it.b_den, bn, b_n, b_d)) begin
        o.status = ST_ZERO;
        return o;
      end
      if (it.kind == K_EQ) begin
        o.truth = (an == bn) && (a_n == b_n) && (a_d == b_d);
        return o;
      end
      if (it.kind == K_LT || it.kind == K_LE) begin
        c = cmp_signed_mag(an, a_n * b_d, bn, b_n * a_d);
        o.truth = (it.kind == K_LT) ? (c < 0) : (c <= 0);
        return o;
      end
      if (it.kind == K_ADD || it.kind == K_SUB) begin
        sb = (it.kind == K_SUB) ? !bn : bn;
        x = a_n * b_d;
        y = b_n * a_d;
        if (b_n == 0) sb = 1'b0;
        if (an == sb) begin
          r_n = x + y; rn = an;
        end else if (x >= y) begin
          r_n = x - y; rn = an;
        end else begin
          r_n = y - x; rn = sb;
        end
        r_d = a_d * b_d;
      end else if (it.kind == K_MUL) begin
        r_n = a_n * b_n; r_d = a_d * b_d; rn = (an != bn);
      end else begin
        if (b_n == 0) begin
          o.status = ST_ZERO;
          return o;
        end
        r_n = a_n * b_d; r_d = a_d * b_n; rn = (an != bn);
      end
      reduce_frac(rn, r_n, r_d);
    end
    if (r_d > lim - 1 || (rn ? r_n > lim : r_n > lim - 1)) begin
      o.status = ST_OVF;
      return o;
    end
    o.res_num = rn ? (32'd0 - r_n[31:0]) : r_n[31:0];
    o.res_den = r_d[30:0];
    o.status  = ST_OK;
    return o;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 12);
      1: return -$urandom_range(1, 12);
      2: return $urandom_range(0, 1000);
      3: return -$urandom_range(0, 1000);
      4: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_den();
    if ($urandom_range(0, 19) == 0) return 32'd0;
    if ($urandom_range(0, 9) == 0) return -$urandom_range(1, 50);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(1, 2000);
  endfunction

  task automatic add_item(logic [2:0] k, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
    rau_in_t it;
    it.kind = k; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
    pending_items = {pending_items, it};
  endtask

  // Driver: change inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_accepted) begin
      // hold until accepted
    end else if (pending_items.size() != 0 && $urandom_range(0, 3) != 0) begin
      in_valid <= 1'b1;
      in_data  <= pending_items.pop_front();
    end else if ($urandom_range(0, 19) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 60)) @(negedge clk);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: a long hold-off right after reset, then random stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_off  <= 3000;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if ($urandom_range(0, 29) == 0) begin
      out_ready <= 1'b0;
      hold_off <= $urandom_range(20, 300);
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Predict at input acceptance; check results at output acceptance
  always @(posedge clk) begin
    in_accepted <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready)
      expected_results = {expected_results, compute_rational(in_data)};
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no item pending: %p", out_data);
        n_errors++;
      end else begin
        rau_out_t e;
        e = expected_results.pop_front();
        if (e.res_num !== out_data.res_num) begin
          $error("res_num exp %0d got %0d", e.res_num, out_data.res_num); n_errors++;
        end
        if (e.res_den !== out_data.res_den) begin
          $error("res_den exp %0d got %0d", e.res_den, out_data.res_den); n_errors++;
        end
        if (e.truth !== out_data.truth) begin
          $error("truth exp %0b got %0b", e.truth, out_data.truth); n_errors++;
        end
        if (e.status !== out_data.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status); n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst)
      cycle_count <= 0;
    else
      cycle_count <= cycle_count + 1;
    if (cycle_count > 3_000_000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [2:0] k;
    rst = 1'b1;
    // directed: every kind, extremes, zero and negative denominators
    add_item(K_MAKE, 6, -4, 0, 0);
    add_item(K_MAKE, 0, -7, 0, 0);
    add_item(K_MAKE, 5, 0, 0, 0);
    add_item(K_MAKE, 32'h8000_0000, 1, 0, 0);
    add_item(K_MAKE, 32'h8000_0000, -1, 0, 0);
    add_item(K_MAKE, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    add_item(K_ADD, 1, 2, 1, 3);
    add_item(K_ADD, 32'h7fff_ffff, 1, 1, 1);
    add_item(K_SUB, 1, 2, 1, 2);
    add_item(K_SUB, 32'h8000_0000, 1, 1, 1);
    add_item(K_MUL, 32'h8000_0000, 1, -1, 1);
    add_item(K_MUL, 4, -6, 9, 2);
    add_item(K_DIV, 1, 3, 0, 5);
    add_item(K_DIV, -3, 4, 5, 32'h7fff_ffff);
    add_item(K_DIV, 1, 2, 3, 0);
    add_item(K_EQ, 2, 4, 1, 2);
    add_item(K_EQ, 1, 2, -1, -2);
    add_item(K_LT, -1, 2, 1, 3);
    add_item(K_LT, 1, 3, 1, 3);
    add_item(K_LE, 1, 3, 2, 6);
    add_item(K_LE, 32'h7fff_ffff, 32'h7fff_fffe, 32'hffff_ffff, 32'hffff_ffff);
    add_item(K_ADD, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 500; i++) begin
      k = 3'($urandom_range(0, 7));
      add_item(k, rand_val(), rand_den(), rand_val(), rand_den());
      while (pending_items.size() > 8) @(posedge clk);
    end
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
